### rtl/adaptive_sample_decimator_unit_defines.svh
// Assertion macros shared by the decimator RTL.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef ADAPTIVE_SAMPLE_DECIMATOR_UNIT_DEFINES_SVH
`define ADAPTIVE_SAMPLE_DECIMATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASDU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("asdu same-cycle check failed");
// next-cycle implication
`define ASDU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("asdu next-cycle check failed");
`else
`define ASDU_ASSERT_NOW(label, ante, cons)
`define ASDU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/asdu_pkg.sv
`timescale 1ns / 1ps

package asdu_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int FRAC_WIDTH_DEF = 16;

    localparam int NOW_W     = 32;
    localparam int FRAC_IN_W = 16;
    localparam int STRIDE_W  = 32;

    localparam logic [FRAC_IN_W-1:0] FRAC_RESET = 16'd655;
    localparam logic [STRIDE_W-1:0]  STRIDE_MAX = 32'hFFFF_FFFF;
    localparam logic [STRIDE_W-1:0]  STRIDE_ONE = 32'd1;

    localparam logic [1:0] CMD_ENTRY = 2'd0;
    localparam logic [1:0] CMD_EXIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_EXIT  = 2'd1;
    localparam logic [1:0] ERR_NO_ENTRY = 2'd2;

    typedef enum logic [1:0] {
        PH_CLEAR   = 2'd0,
        PH_ENTERED = 2'd1,
        PH_READY   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_CALC,
        TS_EMIT
    } t_top_state;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_MUL,
        SQ_DIV,
        SQ_DONE
    } t_seq_state;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [NOW_W-1:0] now;
    } t_in_word;

    typedef struct packed {
        logic       take_sample;
        logic [1:0] error;
        logic [1:0] phase;
    } t_out_word;

endpackage

### rtl/adaptive_sample_decimator_unit.sv
`timescale 1ns / 1ps
`include "adaptive_sample_decimator_unit_defines.svh"

// Adaptive sample decimator: decides per region-entry word whether to sample.
// Input channel: i_in_valid / i_in_data (cmd, now) / o_in_stall.
// Output channel: o_out_valid / o_out_data (take_sample, error, phase) / i_out_stall.
// Every accepted word gives exactly one result word.
// Config: i_cfg_we / i_cfg_wdata writes the overhead fraction (Q0.16); write only while idle.
// Ordinary words land in the output register at the accept edge and show
// in the next cycle; one word per cycle while the output drains.
// Calibrating entry (an entry after an exit in the entered phase) runs the shared
// adder: FRAC_WIDTH multiply steps, then TIME_WIDTH+FRAC_WIDTH divide steps, then
// the result word is loaded from the emit state; a zero divisor skips the
// arithmetic. o_in_stall is high meanwhile.
// Stall: while a result waits under i_out_stall, o_in_stall stays high and the
// output word holds.
// Reset (synchronous, i_rst_n low): phase clear, stride one, count zero,
// overhead fraction 655, no output word pending.
module adaptive_sample_decimator_unit #(
    parameter int TIME_WIDTH = asdu_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_WIDTH = asdu_pkg::FRAC_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  asdu_pkg::t_in_word             i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output asdu_pkg::t_out_word            o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [asdu_pkg::FRAC_IN_W-1:0] i_cfg_wdata
);

    asdu_pkg::t_top_state r_state, n_state;

    // architectural state
    asdu_pkg::t_phase              r_status, n_status;
    logic [TIME_WIDTH-1:0]         r_stamp, n_stamp;
    logic [TIME_WIDTH-1:0]         r_sample, n_sample;
    logic                          r_exit, n_exit;
    logic [asdu_pkg::STRIDE_W-1:0] r_stride;
    logic [asdu_pkg::STRIDE_W-1:0] r_count, n_count;
    logic [asdu_pkg::FRAC_IN_W-1:0] r_frac;

    logic                  r_out_valid;
    asdu_pkg::t_out_word   r_out_data;

    logic                          in_acc, slot_free, load_out, calib, step_take;
    logic [1:0]                    step_err;
    logic [TIME_WIDTH-1:0]         now_t, elapsed;
    logic [asdu_pkg::STRIDE_W-1:0] count_inc;
    logic                          seq_done;
    logic [asdu_pkg::STRIDE_W-1:0] seq_stride;

    assign now_t     = TIME_WIDTH'(i_in_data.now);
    assign elapsed   = now_t - r_stamp;   // wraps mod 2^TIME_WIDTH
    assign count_inc = r_count + asdu_pkg::STRIDE_ONE;
    assign slot_free = !r_out_valid || !i_out_stall;

    // per-word state update
    always_comb begin
        n_status  = r_status;
        n_stamp   = r_stamp;
        n_sample  = r_sample;
        n_exit    = r_exit;
        n_count   = r_count;
        step_take = 1'b0;
        step_err  = asdu_pkg::ERR_NONE;
        calib     = 1'b0;
        unique case (i_in_data.cmd)
            asdu_pkg::CMD_ENTRY: begin
                unique case (r_status)
                    asdu_pkg::PH_CLEAR: begin
                        n_stamp   = now_t;
                        n_exit    = 1'b0;
                        n_status  = asdu_pkg::PH_ENTERED;
                        step_take = 1'b1;
                    end
                    asdu_pkg::PH_ENTERED: begin
                        if (!r_exit) step_err = asdu_pkg::ERR_NO_EXIT;
                        else         calib    = 1'b1;
                    end
                    default: begin
                        if (count_inc == r_stride) begin
                            n_count   = '0;
                            step_take = 1'b1;
                        end else begin
                            n_count = count_inc;
                        end
                    end
                endcase
            end
            asdu_pkg::CMD_EXIT: begin
                unique case (r_status)
                    asdu_pkg::PH_CLEAR:   step_err = asdu_pkg::ERR_NO_ENTRY;
                    asdu_pkg::PH_ENTERED: begin
                        n_sample = elapsed;
                        n_exit   = 1'b1;
                    end
                    default: ;  // exit while ready is ignored
                endcase
            end
            asdu_pkg::CMD_CLEAR: n_status = asdu_pkg::PH_CLEAR;
            default: ;          // unused command
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asdu_pkg::TS_IDLE: begin
                if (in_acc && calib) n_state = asdu_pkg::TS_CALC;
            end
            asdu_pkg::TS_CALC: begin
                if (seq_done) n_state = asdu_pkg::TS_EMIT;
            end
            asdu_pkg::TS_EMIT: begin
                if (slot_free) n_state = asdu_pkg::TS_IDLE;
            end
            default: n_state = asdu_pkg::TS_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != asdu_pkg::TS_IDLE) || !slot_free;
        in_acc     = i_in_valid && !o_in_stall;
        load_out   = 1'b0;
        unique case (r_state)
            asdu_pkg::TS_IDLE: load_out = in_acc && !calib;
            asdu_pkg::TS_EMIT: load_out = slot_free;
            default:           load_out = 1'b0;
        endcase
    end

    asdu_seq #(
        .TIME_WIDTH (TIME_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc && calib),
        .i_sample (r_sample),
        .i_work   (elapsed),
        .i_frac   (FRAC_WIDTH'(r_frac)),
        .o_done   (seq_done),
        .o_stride (seq_stride)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asdu_pkg::TS_IDLE;
            r_status    <= asdu_pkg::PH_CLEAR;
            r_stamp     <= '0;
            r_sample    <= '0;
            r_exit      <= 1'b0;
            r_stride    <= asdu_pkg::STRIDE_ONE;
            r_count     <= '0;
            r_frac      <= asdu_pkg::FRAC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_frac <= i_cfg_wdata;
            if (in_acc) begin
                r_status <= n_status;
                r_stamp  <= n_stamp;
                r_sample <= n_sample;
                r_exit   <= n_exit;
                r_count  <= n_count;
            end
            if (seq_done) begin
                r_stride <= seq_stride;
                r_count  <= '0;
                r_status <= asdu_pkg::PH_READY;
            end
            if (load_out)         r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // result word, no reset needed
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_state == asdu_pkg::TS_EMIT) begin
                r_out_data.take_sample <= 1'b1;
                r_out_data.error       <= asdu_pkg::ERR_NONE;
                r_out_data.phase       <= asdu_pkg::PH_READY;
            end else begin
                r_out_data.take_sample <= step_take;
                r_out_data.error       <= step_err;
                r_out_data.phase       <= n_status;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASDU_ASSERT_NOW(a_busy_stalls, r_state != asdu_pkg::TS_IDLE, o_in_stall)
    `ASDU_ASSERT_NOW(a_emit_ready, r_state == asdu_pkg::TS_EMIT,
                     r_status == asdu_pkg::PH_READY)
    `ASDU_ASSERT_NOW(a_stride_valid, r_status == asdu_pkg::PH_READY, r_stride != '0)
    `ASDU_ASSERT_NEXT(a_calib_no_out, in_acc && calib, !load_out)

endmodule

### rtl/asdu_addsub.sv
`timescale 1ns / 1ps

// Shared adder/subtractor. o_carry on subtract means i_a >= i_b.
module asdu_addsub #(
    parameter int W = 49
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);

    logic [W:0] sum_ext;

    always_comb begin
        sum_ext = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + {{W{1'b0}}, i_sub};
    end

    assign o_sum   = sum_ext[W-1:0];
    assign o_carry = sum_ext[W];

endmodule

### rtl/asdu_seq.sv
`timescale 1ns / 1ps
`include "adaptive_sample_decimator_unit_defines.svh"

// Stride calculator: shift-add multiply for the divisor, then restoring
// divide, both on one adder.
module asdu_seq #(
    parameter int TIME_WIDTH = asdu_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_WIDTH = asdu_pkg::FRAC_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [TIME_WIDTH-1:0]         i_sample,
    input  logic [TIME_WIDTH-1:0]         i_work,
    input  logic [FRAC_WIDTH-1:0]         i_frac,
    output logic                          o_done,
    output logic [asdu_pkg::STRIDE_W-1:0] o_stride
);

    localparam int NUM_W = TIME_WIDTH + FRAC_WIDTH;
    localparam int DEN_W = TIME_WIDTH + FRAC_WIDTH;
    localparam int ALU_W = DEN_W + 1;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int Q_W   = asdu_pkg::STRIDE_W + 1;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FRAC_WIDTH - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
    localparam logic [Q_W-1:0]   Q_SAT    = {1'b0, asdu_pkg::STRIDE_MAX} - Q_W'(1);

    asdu_pkg::t_seq_state r_state, n_state;

    logic [TIME_WIDTH-1:0] r_mcand;
    logic [FRAC_WIDTH-1:0] r_mplier;
    logic [DEN_W-1:0]      r_acc;     // product, then divisor
    logic [NUM_W-1:0]      r_num;
    logic [DEN_W-1:0]      r_rem;
    logic [Q_W-1:0]        r_q;
    logic                  r_sat;
    logic [CNT_W-1:0]      r_cnt;

    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;
    logic [Q_W:0]     q_ext;
    logic             zero_div;

    asdu_addsub #(.W(ALU_W)) u_addsub (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign zero_div = (i_frac == '0) || (i_work == '0);
    assign q_ext    = {r_q, alu_carry};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asdu_pkg::SQ_IDLE: begin
                if (i_start) n_state = zero_div ? asdu_pkg::SQ_DONE : asdu_pkg::SQ_MUL;
            end
            asdu_pkg::SQ_MUL: begin
                if (r_cnt == '0) n_state = asdu_pkg::SQ_DIV;
            end
            asdu_pkg::SQ_DIV: begin
                if (r_cnt == '0) n_state = asdu_pkg::SQ_DONE;
            end
            asdu_pkg::SQ_DONE: n_state = asdu_pkg::SQ_IDLE;
            default:           n_state = asdu_pkg::SQ_IDLE;
        endcase
    end

    // adder operands and outputs
    always_comb begin
        alu_a   = {r_acc, 1'b0};
        alu_b   = r_mplier[FRAC_WIDTH-1] ? ALU_W'(r_mcand) : '0;
        alu_sub = 1'b0;
        unique case (r_state)
            asdu_pkg::SQ_DIV: begin
                alu_a   = {r_rem, r_num[NUM_W-1]};
                alu_b   = {1'b0, r_acc};
                alu_sub = 1'b1;
            end
            default: ;
        endcase
        o_done   = (r_state == asdu_pkg::SQ_DONE);
        o_stride = (r_sat || r_q >= Q_SAT) ? asdu_pkg::STRIDE_MAX
                                           : r_q[asdu_pkg::STRIDE_W-1:0] + asdu_pkg::STRIDE_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asdu_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            asdu_pkg::SQ_IDLE: begin
                if (i_start) begin
                    r_mcand  <= i_work;
                    r_mplier <= i_frac;
                    r_num    <= {i_sample, {FRAC_WIDTH{1'b0}}};
                    r_acc    <= '0;
                    r_rem    <= '0;
                    r_q      <= '0;
                    r_sat    <= zero_div;
                    r_cnt    <= MUL_LAST;
                end
            end
            asdu_pkg::SQ_MUL: begin
                r_acc    <= alu_sum[DEN_W-1:0];
                r_mplier <= r_mplier << 1;
                r_cnt    <= (r_cnt == '0) ? DIV_LAST : r_cnt - CNT_W'(1);
            end
            asdu_pkg::SQ_DIV: begin
                r_rem <= alu_carry ? alu_sum[DEN_W-1:0] : alu_a[DEN_W-1:0];
                r_num <= r_num << 1;
                r_q   <= q_ext[Q_W-1:0];
                r_sat <= r_sat | q_ext[Q_W];
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: ;
        endcase
    end

    `ASDU_ASSERT_NOW(a_start_idle, i_start, r_state == asdu_pkg::SQ_IDLE)
    `ASDU_ASSERT_NOW(a_stride_nonzero, o_done, o_stride != '0)
    `ASDU_ASSERT_NOW(a_sat_max, o_done && r_sat, o_stride == asdu_pkg::STRIDE_MAX)
    `ASDU_ASSERT_NEXT(a_done_once, o_done, !o_done)

endmodule

### dv/adaptive_sample_decimator_unit_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each result word and compares in order.
module adaptive_sample_decimator_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  asdu_pkg::t_in_word             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  asdu_pkg::t_out_word            i_out_data,
    input  logic                           i_cfg_we,
    input  logic [asdu_pkg::FRAC_IN_W-1:0] i_cfg_wdata,
    output logic [31:0]                    o_fail_count,
    output logic [31:0]                    o_pending
);
    import asdu_pkg::*;

    t_phase                ph;
    logic [NOW_W-1:0]      entry_stamp_q;
    logic [NOW_W-1:0]      sample_dur_q;
    logic                  exit_seen_q;
    logic [STRIDE_W-1:0]   stride_q;
    logic [STRIDE_W-1:0]   entry_count_q;
    logic [FRAC_IN_W-1:0]  frac_q;
    t_out_word             expected_decisions[$];
    int                    fail_total = 0;

    // floor(dur * 2^16 / (frac * work)) + 1, saturating
    function automatic logic [STRIDE_W-1:0] calibrate_stride(input logic [NOW_W-1:0] dur,
                                                             input logic [NOW_W-1:0] work,
                                                             input logic [FRAC_IN_W-1:0] frac);
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] quot;
        if (frac == '0 || work == '0) begin
            return STRIDE_MAX;
        end
        numer = {16'd0, dur, 16'd0};
        denom = 64'(frac) * 64'(work);
        quot  = numer / denom;
        if (quot >= 64'(STRIDE_MAX) - 64'd1) begin
            return STRIDE_MAX;
        end
        return quot[STRIDE_W-1:0] + STRIDE_ONE;
    endfunction

    function automatic t_out_word decide_sample(input t_in_word w);
        t_out_word r;
        r             = '0;
        r.error       = ERR_NONE;
        r.take_sample = 1'b0;
        case (w.cmd)
            CMD_ENTRY: begin
                case (ph)
                    PH_CLEAR: begin
                        entry_stamp_q = w.now;
                        exit_seen_q   = 1'b0;
                        ph            = PH_ENTERED;
                        r.take_sample = 1'b1;
                    end
                    PH_ENTERED: begin
                        if (!exit_seen_q) begin
                            r.error = ERR_NO_EXIT;
                        end else begin
                            stride_q      = calibrate_stride(sample_dur_q,
                                                             w.now - entry_stamp_q, frac_q);
                            entry_count_q = '0;
                            ph            = PH_READY;
                            r.take_sample = 1'b1;
                        end
                    end
                    PH_READY: begin
                        entry_count_q = entry_count_q + 1'b1;
                        if (entry_count_q == stride_q) begin
                            entry_count_q = '0;
                            r.take_sample = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_EXIT: begin
                if (ph == PH_CLEAR) begin
                    r.error = ERR_NO_ENTRY;
                end else if (ph == PH_ENTERED) begin
                    sample_dur_q = w.now - entry_stamp_q;
                    exit_seen_q  = 1'b1;
                end
            end
            CMD_CLEAR: begin
                ph = PH_CLEAR;
            end
            default: ;
        endcase
        r.phase = ph;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            ph            = PH_CLEAR;
            entry_stamp_q = '0;
            sample_dur_q  = '0;
            exit_seen_q   = 1'b0;
            stride_q      = STRIDE_ONE;
            entry_count_q = '0;
            frac_q        = FRAC_RESET;
            expected_decisions.delete();
        end else begin
            // retire first: a word accepted now can only show up later
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_decisions.size() == 0) begin
                    $error("result word with no expectation pending: %p", got);
                    fail_total++;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.take_sample !== want.take_sample) begin
                        $error("take_sample: expected %0d, got %0d",
                               want.take_sample, got.take_sample);
                        fail_total++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        fail_total++;
                    end
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        fail_total++;
                    end
                end
            end
            if (i_cfg_we) begin
                frac_q = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_decisions.push_back(decide_sample(i_in_data));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_decisions.size();
    end

endmodule

### dv/adaptive_sample_decimator_unit_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the adaptive sample decimator.
// Prediction and comparison live in the checker instantiated beside the DUT.
module adaptive_sample_decimator_unit_tb;
    import asdu_pkg::*;

    // cmd encoding 3 is unused by the block: must be ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET  = 1900;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off, fills the DUT
    localparam int SETTLE       = 80;       // wait after the final drain
    localparam int CYCLE_LIMIT  = 1000000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_word            out_word;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [FRAC_IN_W-1:0] cfg_wdata = '0;
    logic [31:0]          fail_count;
    logic [31:0]          pending;

    int                   cycle_count   = 0;
    int                   words_sent    = 0;
    bit                   fast_mode     = 1'b0;  // no idling on either side
    bit                   long_hold_req = 1'b0;
    logic [FRAC_IN_W-1:0] cur_frac      = FRAC_RESET;  // used only to shape stimulus

    adaptive_sample_decimator_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    adaptive_sample_decimator_unit_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("adaptive_sample_decimator_unit_tb failed");
            $finish;
        end
    end

    // Offer one word after a random gap; returns at the edge that accepts it.
    // Valid stays high after acceptance until the next falling edge, where it
    // either drops for a gap or carries the next word.
    task automatic send_word(input logic [1:0] op, input logic [NOW_W-1:0] stamp);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= {op, stamp};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and wait until every predicted word has come back.
    // Checked at falling edges so the checker's count has settled.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // overhead fraction write, only with the block idle
    task automatic write_frac(input logic [FRAC_IN_W-1:0] val);
        drain();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_frac   = val;
    endtask

    // One well-formed calibration sequence with random content, then a run of
    // entries in the ready phase sprinkled with noise words.
    task automatic run_session(input int n_entries, input int noise_pct);
        logic [NOW_W-1:0] t0;
        logic [NOW_W-1:0] dur;
        logic [NOW_W-1:0] work;
        logic [NOW_W-1:0] t;
        logic [63:0]      scaled;
        int               n_exits;
        int               r;
        send_word(CMD_CLEAR, $urandom);
        t0 = $urandom;
        send_word(CMD_ENTRY, t0);
        // occasionally a second entry before any exit
        if ($urandom_range(0, 9) == 0) begin
            send_word(CMD_ENTRY, t0 + $urandom_range(0, 100));
        end
        case ($urandom_range(0, 9))
            0:       work = '0;                       // zero work period
            1:       work = $urandom;                 // anything, wraps
            default: work = $urandom_range(1, 20000);
        endcase
        // aim the stride at roughly 1..13 so sampled entries are frequent
        scaled = (64'($urandom_range(0, 12)) * 64'(cur_frac) * 64'(work)) >> 16;
        dur    = scaled[NOW_W-1:0] + $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) begin
            dur = $urandom;
        end
        // last exit wins; earlier ones carry junk durations
        n_exits = $urandom_range(1, 3);
        for (int i = 1; i < n_exits; i++) begin
            send_word(CMD_EXIT, t0 + $urandom);
        end
        send_word(CMD_EXIT, t0 + dur);
        send_word(CMD_ENTRY, t0 + work);
        t = t0 + work;
        for (int i = 0; i < n_entries; i++) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct) begin
                send_word(2'($urandom_range(0, 3)), $urandom);
            end else if (r < noise_pct + 5) begin
                send_word(CMD_EXIT, t);               // ignored once ready
            end else begin
                t = t + $urandom_range(1, 5000);
                send_word(CMD_ENTRY, t);
            end
        end
    endtask

    // Receiver: random stall before each word, a long hold-off on request.
    initial begin : rx_proc
        int hold;
        wait (rst_n);
        forever begin
            if (long_hold_req) begin
                hold          = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else begin
                hold = fast_mode ? 0 : $urandom_range(0, 16);
            end
            if (hold > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stim_proc
        int                   first_random;
        int                   session_idx;
        logic [FRAC_IN_W-1:0] f;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part, default overhead fraction ---
        send_word(CMD_EXIT, 32'h0000_0000);     // exit while clear: no-entry error
        send_word(CMD_UNUSED, 32'hFFFF_FFFF);   // unused code while clear
        send_word(CMD_CLEAR, 32'h0000_0000);    // clear while already clear
        send_word(CMD_ENTRY, 32'hFFFF_FFF0);    // first entry, sampled
        send_word(CMD_ENTRY, 32'h0000_0000);    // entry without exit: error
        send_word(CMD_EXIT, 32'h0000_0005);     // duration wraps past zero
        send_word(CMD_EXIT, 32'h0000_0010);     // repeated exit, this one counts
        send_word(CMD_ENTRY, 32'hFFFF_FFF0);    // zero work period: stride saturates
        send_word(CMD_ENTRY, 32'h0000_0001);
        send_word(CMD_ENTRY, 32'h0000_0002);
        send_word(CMD_EXIT, 32'h0000_0003);     // exit while ready: ignored
        send_word(CMD_UNUSED, 32'h0000_0004);
        send_word(CMD_CLEAR, 32'h0000_0005);
        send_word(CMD_ENTRY, 32'h0000_0000);
        send_word(CMD_EXIT, 32'hFFFF_FFFF);     // longest duration
        send_word(CMD_ENTRY, 32'h0000_0001);    // quotient overflows: saturates

        write_frac(16'hFFFF);                   // widest fraction
        send_word(CMD_CLEAR, 32'd0);
        send_word(CMD_ENTRY, 32'd100);
        send_word(CMD_EXIT, 32'd100);           // zero duration: stride one
        send_word(CMD_ENTRY, 32'd200);
        send_word(CMD_ENTRY, 32'd300);
        send_word(CMD_ENTRY, 32'd400);

        write_frac(16'h0000);                   // zero fraction: divisor zero
        send_word(CMD_CLEAR, 32'd0);
        send_word(CMD_ENTRY, 32'd10);
        send_word(CMD_EXIT, 32'd20);
        send_word(CMD_ENTRY, 32'd30);

        write_frac(16'h0001);                   // smallest nonzero fraction
        send_word(CMD_CLEAR, 32'd0);
        send_word(CMD_ENTRY, 32'd0);
        send_word(CMD_EXIT, 32'd1);
        send_word(CMD_ENTRY, 32'h0001_0000);    // stride two
        send_word(CMD_ENTRY, 32'h0001_0001);
        send_word(CMD_ENTRY, 32'h0001_0002);
        send_word(CMD_ENTRY, 32'h0001_0003);

        write_frac(FRAC_RESET);

        // --- random part ---
        first_random = words_sent;
        session_idx  = 0;
        while (words_sent - first_random < ITEM_TARGET) begin
            fast_mode = ($urandom_range(0, 4) == 0);
            if (session_idx == 5) begin
                long_hold_req = 1'b1;
            end
            if (session_idx % 6 == 3) begin
                case ($urandom_range(0, 5))
                    0:       f = 16'h0001;
                    1:       f = 16'hFFFF;
                    2:       f = 16'h0000;
                    3:       f = FRAC_IN_W'($urandom_range(1, 65535));
                    default: f = FRAC_IN_W'($urandom_range(1, 4000));
                endcase
                write_frac(f);
            end else if (session_idx == 8) begin
                drain();                       // full pause, nothing in flight
            end
            run_session($urandom_range(4, 40), $urandom_range(0, 15));
            session_idx++;
        end

        drain();
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("adaptive_sample_decimator_unit_tb passed");
        end else begin
            $display("adaptive_sample_decimator_unit_tb failed");
        end
        $finish;
    end

endmodule
